@@ src/aeiu_pkg.sv @@
package aeiu_pkg;

  // Coding state width and the derived bit positions.
  localparam int unsigned StateBits = 32;
  localparam int unsigned ShiftCntW = $clog2(StateBits);

  // Field widths.
  localparam int unsigned FreqW = 31;
  localparam int unsigned SpanW = StateBits + 1;
  localparam int unsigned ProdW = SpanW + FreqW;
  localparam int unsigned QuotW = SpanW;
  localparam int unsigned StepCntW = $clog2(ProdW);

  // Largest frequency total that keeps every symbol slice non-empty.
  localparam logic [FreqW-1:0] TotalLimit = FreqW'((64'd1 << 30) + 64'd2);
  localparam logic [FreqW-1:0] FreqTotalReset = FreqW'(65536);

  // Phases of the serial multiply-divide unit.
  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_e;

  // Phases of the encoder sequencer.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SINGLE = 5'b00010,
    S_CALC   = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_UNDER  = 5'b10000
  } state_e;

endpackage

@@ src/aeiu_muldiv.sv @@
// Bit-serial computation of floor(span * mult / divisor). A shift-add multiply
// runs one multiplier bit per cycle, then a restoring division shifts the
// product out one bit per cycle and shifts the quotient into the same register.
module aeiu_muldiv (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [aeiu_pkg::SpanW-1:0] span_i,
  input  logic [aeiu_pkg::FreqW-1:0] mult_i,
  input  logic [aeiu_pkg::FreqW-1:0] divisor_i,
  output logic                      done_o,
  output logic [aeiu_pkg::QuotW-1:0] quot_o
);
  import aeiu_pkg::*;

  localparam logic [StepCntW-1:0] MulLast = StepCntW'(FreqW - 1);
  localparam logic [StepCntW-1:0] DivLast = StepCntW'(ProdW - 1);

  md_state_e             state_q, state_d;
  logic [StepCntW-1:0]   cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [SpanW-1:0]      span_q, span_d;
  logic [ProdW-1:0]      prod_q, prod_d;
  logic [FreqW-1:0]      rem_q, rem_d;

  logic [SpanW-1:0]      addend;
  logic [SpanW:0]        mul_sum;
  logic [FreqW:0]        trial;
  logic                  fits;

  assign addend  = prod_q[0] ? span_q : '0;
  assign mul_sum = {1'b0, prod_q[ProdW-1:FreqW]} + {1'b0, addend};
  assign trial   = {rem_q, prod_q[ProdW-1]};
  assign fits    = trial >= {1'b0, divisor_i};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    span_d  = span_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          span_d  = span_i;
          prod_d  = {{(ProdW-FreqW){1'b0}}, mult_i};
          rem_d   = '0;
          cnt_d   = '0;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        prod_d = {mul_sum, prod_q[FreqW-1:1]};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == MulLast) begin
          cnt_d   = '0;
          state_d = MD_DIV;
        end
      end
      MD_DIV: begin
        prod_d = {prod_q[ProdW-2:0], fits};
        rem_d  = fits ? FreqW'(trial - {1'b0, divisor_i}) : trial[FreqW-1:0];
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          done_d  = 1'b1;
          state_d = MD_IDLE;
        end
      end
      default: begin
        state_d = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q <= span_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = prod_q[QuotW-1:0];

endmodule

@@ src/arithmetic_encoder_interval_update.sv @@
// Binary arithmetic encoder with 32-bit low/high state. An input beat either
// narrows the coding interval to the symbol slice [sym_low, sym_high) of the
// configured frequency total (mode 0) or requests the final flush (mode 1).
// Each encode beat yields zero to 32 output beats, one per shifted-out bit,
// the final one marked with last; flush and invalid intervals give exactly
// one beat. An encode beat runs through the two bit-serial multiply-divide
// units, one for sym_low and one for sym_high side by side: 31 multiply
// steps, then 64 divide steps, then the quotients are handed over. After
// that, renormalization emits a beat for each settled bit, then expands the
// middle once per underflow step and returns to idle. Every beat waits while
// the output register is full and not being drained. One input item is
// worked on at a time, while the output register lets the last result wait
// without holding up the next input.
module arithmetic_encoder_interval_update (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port for freq_total.
  input  logic                       cfg_we_i,
  input  logic [aeiu_pkg::FreqW-1:0] cfg_wdata_i,
  // Input channel.
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [aeiu_pkg::FreqW-1:0] sym_low_i,
  input  logic [aeiu_pkg::FreqW-1:0] sym_high_i,
  // Output channel.
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       lead_bit_o,
  output logic [aeiu_pkg::StateBits-1:0] follow_count_o,
  output logic                       last_o,
  output logic                       error_o
);
  import aeiu_pkg::*;

  localparam logic [ShiftCntW-1:0] ShiftLast = ShiftCntW'(StateBits - 1);

  // Saturating increment of the pending underflow counter.
  function automatic logic [StateBits-1:0] pend_inc(input logic [StateBits-1:0] value);
    pend_inc = (value == '1) ? value : value + 1'b1;
  endfunction

  state_e                 state_q, state_d;
  logic [FreqW-1:0]       freq_total_q;
  logic [StateBits-1:0]   range_low_q, range_low_d;
  logic [StateBits-1:0]   range_high_q, range_high_d;
  logic [StateBits-1:0]   pending_q, pending_d;
  logic [ShiftCntW-1:0]   shift_cnt_q, shift_cnt_d;
  logic                   single_err_q, single_err_d;

  logic                   out_valid_q, out_valid_d;
  logic                   lead_bit_q, lead_bit_d;
  logic [StateBits-1:0]   follow_q, follow_d;
  logic                   last_q, last_d;
  logic                   error_q, error_d;

  logic                   in_accept;
  logic                   out_free;
  logic                   slice_ok;
  logic                   md_start;
  logic [SpanW-1:0]       span;
  logic                   hi_done, lo_done;
  logic [QuotW-1:0]       hi_quot, lo_quot;
  logic                   top_shared;
  logic                   underflow;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  // The output register can take a new beat when it is empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;

  // The slice must be non-empty, inside the total, and the total in range.
  assign slice_ok = (sym_low_i < sym_high_i) && (sym_high_i <= freq_total_q) &&
                    (freq_total_q <= TotalLimit);
  assign md_start = in_accept && !mode_i && slice_ok;

  // Width of the current interval, up to 2^32 when the range is full.
  assign span = {1'b0, range_high_q} - {1'b0, range_low_q} + SpanW'(1);

  aeiu_muldiv u_muldiv_hi (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (md_start),
    .span_i    (span),
    .mult_i    (sym_high_i),
    .divisor_i (freq_total_q),
    .done_o    (hi_done),
    .quot_o    (hi_quot)
  );

  aeiu_muldiv u_muldiv_lo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (md_start),
    .span_i    (span),
    .mult_i    (sym_low_i),
    .divisor_i (freq_total_q),
    .done_o    (lo_done),
    .quot_o    (lo_quot)
  );

  // Low and high agree in their top bit: that bit is settled and goes out.
  assign top_shared = (range_low_q[StateBits-1] == range_high_q[StateBits-1]);
  // Low sits in the second quarter and high in the third: expand the middle.
  assign underflow  = range_low_q[StateBits-2] && !range_high_q[StateBits-2];

  always_comb begin
    state_d      = state_q;
    range_low_d  = range_low_q;
    range_high_d = range_high_q;
    pending_d    = pending_q;
    shift_cnt_d  = shift_cnt_q;
    single_err_d = single_err_q;

    out_valid_d  = out_valid_q && !out_ready_i;
    lead_bit_d   = lead_bit_q;
    follow_d     = follow_q;
    last_d       = last_q;
    error_d      = error_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (mode_i) begin
            single_err_d = 1'b0;
            state_d      = S_SINGLE;
          end else if (!slice_ok) begin
            single_err_d = 1'b1;
            state_d      = S_SINGLE;
          end else begin
            state_d = S_CALC;
          end
        end
      end
      S_SINGLE: begin
        // Flush or error: exactly one beat, marked last.
        if (out_free) begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          error_d     = single_err_q;
          if (single_err_q) begin
            lead_bit_d = 1'b0;
            follow_d   = '0;
          end else begin
            // The flush bit is 1 once low has reached a quarter of the range.
            lead_bit_d = |range_low_q[StateBits-1:StateBits-2];
            follow_d   = pend_inc(pending_q);
            pending_d  = '0;
          end
          state_d = S_IDLE;
        end
      end
      S_CALC: begin
        // Both units finish in the same cycle; narrow the interval from the old low.
        if (hi_done) begin
          range_high_d = range_low_q + hi_quot[StateBits-1:0] - StateBits'(1);
          range_low_d  = range_low_q + lo_quot[StateBits-1:0];
          shift_cnt_d  = '0;
          state_d      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!top_shared) begin
          state_d = S_UNDER;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          lead_bit_d   = range_low_q[StateBits-1];
          follow_d     = pending_q;
          error_d      = 1'b0;
          // This beat is the last when the next top bits differ or all bits are gone.
          last_d       = (range_low_q[StateBits-2] != range_high_q[StateBits-2]) ||
                         (shift_cnt_q == ShiftLast);
          pending_d    = '0;
          range_low_d  = {range_low_q[StateBits-2:0], 1'b0};
          range_high_d = {range_high_q[StateBits-2:0], 1'b1};
          shift_cnt_d  = shift_cnt_q + 1'b1;
          if (last_d) begin
            state_d = S_UNDER;
          end
        end
      end
      S_UNDER: begin
        if (underflow) begin
          pending_d    = pend_inc(pending_q);
          range_low_d  = {1'b0, range_low_q[StateBits-3:0], 1'b0};
          range_high_d = {1'b1, range_high_q[StateBits-3:0], 1'b1};
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      freq_total_q <= FreqTotalReset;
      range_low_q  <= '0;
      range_high_q <= '1;
      pending_q    <= '0;
      shift_cnt_q  <= '0;
      single_err_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      range_low_q  <= range_low_d;
      range_high_q <= range_high_d;
      pending_q    <= pending_d;
      shift_cnt_q  <= shift_cnt_d;
      single_err_q <= single_err_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        freq_total_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lead_bit_q <= lead_bit_d;
    follow_q   <= follow_d;
    last_q     <= last_d;
    error_q    <= error_d;
  end

  assign out_valid_o    = out_valid_q;
  assign lead_bit_o     = lead_bit_q;
  assign follow_count_o = follow_q;
  assign last_o         = last_q;
  assign error_o        = error_q;

`ifndef SYNTHESIS
  // An accepted beat always takes the sequencer out of idle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("input accepted but sequencer stayed idle");

  // The two multiply-divide units run in lockstep.
  a_units_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_done == lo_done)
    else $error("multiply-divide units out of step");

  // An error beat carries no bit and closes its item.
  a_error_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (last_o && !lead_bit_o && (follow_count_o == '0)))
    else $error("malformed error beat");

  // Renormalization always starts with a cleared shift count.
  a_shift_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC && hi_done) |=> (state_q == S_SHIFT && shift_cnt_q == '0))
    else $error("renormalization entered with stale shift count");
`endif

endmodule
